### src/pctd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prefix code tree decoder package
// Field layout of the stream channels, result kinds, actions, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pctd_pkg;

  localparam int ACTION_W  = 2;
  localparam int SYMBOL_W  = 8;
  localparam int CODE_W    = 16;
  localparam int LEN_W     = 5;
  localparam int BYTE_W    = 8;
  localparam int VBITS_W   = 4;
  localparam int KIND_W    = 2;

  localparam int SYM_LSB   = 0;
  localparam int CODE_LSB  = SYM_LSB + SYMBOL_W;
  localparam int LEN_LSB   = CODE_LSB + CODE_W;
  localparam int BYTE_LSB  = LEN_LSB + LEN_W;
  localparam int VBITS_LSB = BYTE_LSB + BYTE_W;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = SYMBOL_W;

  localparam logic [VBITS_W-1:0] BYTE_BITS = VBITS_W'(8);

  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DECODE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_SYMBOL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INVALID = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd3;

  localparam logic [1:0] RD_NODE = 2'd0;
  localparam logic [1:0] RD_WALK = 2'd1;
  localparam logic [1:0] RD_NEXT = 2'd2;

  typedef struct packed {
    logic              load;
    logic              clear_tree;
    logic [1:0]        rd_sel;
    logic              add_follow;
    logic              add_create;
    logic              add_zero;
    logic              dec_load_cur;
    logic              dec_invalid;
    logic              dec_leaf;
    logic              dec_descend;
    logic              produce;
    logic [KIND_W-1:0] produce_kind;
    logic              flush;
  } cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] in_action;
    logic                in_len_zero;
    logic                in_nbits_zero;
    logic                add_link_zero;
    logic                full;
    logic                add_last;
    logic                dec_next_zero;
    logic                dec_leaf;
    logic                dec_last;
    logic                pend_valid;
    logic                slot_free;
  } status_t;

endpackage

### src/pctd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pctd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### src/pctd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prefix code tree decoder datapath
// Node tree memories, root links, walk registers, pending result and the
// output register.
// ----------------------------------------------------------------------------
module pctd_datapath import pctd_pkg::*; #(
  parameter int MAX_NODES       = 512,
  parameter int MAX_CODE_LENGTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [ACTION_W-1:0]   s_tuser,
  input  cmd_t                  cmd,
  output status_t               st,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [KIND_W-1:0]     m_tuser,
  output logic                  m_tlast
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int USED_W = $clog2(MAX_NODES + 1);
  localparam int CNT_W  = $clog2(MAX_CODE_LENGTH + 1);

  logic [SYMBOL_W-1:0] in_symbol;
  logic [CODE_W-1:0]   in_code;
  logic [LEN_W-1:0]    in_len;
  logic [BYTE_W-1:0]   in_byte;
  logic [VBITS_W-1:0]  in_vbits;

  logic [SYMBOL_W-1:0] symbol_r;
  logic [CODE_W-1:0]   code_r;
  logic [CNT_W-1:0]    bits_left;
  logic [BYTE_W-1:0]   data_sh;
  logic [VBITS_W-1:0]  nbit_cnt;
  logic [NODE_W-1:0]   node;
  logic [NODE_W-1:0]   walk;
  logic [NODE_W-1:0]   cur_l;
  logic [NODE_W-1:0]   cur_r;
  logic [NODE_W-1:0]   root_l;
  logic [NODE_W-1:0]   root_r;
  logic [USED_W-1:0]   nodes_used;

  logic                pend_valid;
  logic [KIND_W-1:0]   pend_kind;
  logic [SYMBOL_W-1:0] pend_sym;
  logic                out_valid;
  logic [KIND_W-1:0]   out_kind;
  logic [SYMBOL_W-1:0] out_sym;
  logic                out_last;

  logic [NODE_W-1:0]   left_q;
  logic [NODE_W-1:0]   right_q;
  logic [SYMBOL_W-1:0] sym_q;
  logic [NODE_W-1:0]   rd_addr;
  logic                left_we;
  logic [NODE_W-1:0]   left_wa;
  logic [NODE_W-1:0]   left_wd;
  logic                right_we;
  logic [NODE_W-1:0]   right_wa;
  logic [NODE_W-1:0]   right_wd;
  logic                sym_we;
  logic [NODE_W-1:0]   sym_wa;
  logic [SYMBOL_W-1:0] sym_wd;

  logic [CODE_W-1:0]   code_shift;
  logic                add_bit;
  logic                add_last;
  logic [NODE_W-1:0]   add_link;
  logic [NODE_W-1:0]   fresh;
  logic                node_is_root;
  logic [NODE_W-1:0]   dec_next;
  logic                slot_free;
  logic [SYMBOL_W-1:0] new_sym;

  assign in_symbol = s_tdata[SYM_LSB +: SYMBOL_W];
  assign in_code   = s_tdata[CODE_LSB +: CODE_W];
  assign in_len    = s_tdata[LEN_LSB +: LEN_W];
  assign in_byte   = s_tdata[BYTE_LSB +: BYTE_W];
  assign in_vbits  = s_tdata[VBITS_LSB +: VBITS_W];

  assign code_shift   = code_r >> (bits_left - CNT_W'(1));
  assign add_bit      = code_shift[0];
  assign add_last     = (bits_left == CNT_W'(1));
  assign node_is_root = (node == '0);
  assign fresh        = nodes_used[NODE_W-1:0];
  assign dec_next     = data_sh[0] ? cur_r : cur_l;
  assign slot_free    = !out_valid || m_tready;
  assign new_sym      = (cmd.produce_kind == KIND_SYMBOL) ? sym_q : '0;

  always_comb begin
    if (add_bit) begin
      add_link = node_is_root ? root_r : right_q;
    end else begin
      add_link = node_is_root ? root_l : left_q;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_NODE: rd_addr = node;
      RD_WALK: rd_addr = walk;
      default: rd_addr = dec_next;
    endcase
  end

  always_comb begin
    left_we  = 1'b0;
    left_wa  = node;
    left_wd  = '0;
    right_we = 1'b0;
    right_wa = node;
    right_wd = '0;
    sym_we   = 1'b0;
    sym_wa   = fresh;
    sym_wd   = '0;
    if (cmd.add_create) begin
      if (add_bit) begin
        left_we  = 1'b1;
        left_wa  = fresh;
        right_we = !node_is_root;
        right_wd = fresh;
      end else begin
        right_we = 1'b1;
        right_wa = fresh;
        left_we  = !node_is_root;
        left_wd  = fresh;
      end
      sym_we = 1'b1;
      sym_wd = add_last ? symbol_r : '0;
    end
    if (cmd.add_zero) begin
      left_we  = !add_bit;
      right_we = add_bit;
    end
    if (cmd.add_follow && add_last) begin
      sym_we = 1'b1;
      sym_wa = add_link;
      sym_wd = symbol_r;
    end
  end

  pctd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_left_ram (
    .clk     (clk),
    .wr_en   (left_we),
    .wr_addr (left_wa),
    .wr_data (left_wd),
    .rd_addr (rd_addr),
    .rd_data (left_q)
  );

  pctd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_right_ram (
    .clk     (clk),
    .wr_en   (right_we),
    .wr_addr (right_wa),
    .wr_data (right_wd),
    .rd_addr (rd_addr),
    .rd_data (right_q)
  );

  pctd_ram #(.WIDTH(SYMBOL_W), .DEPTH(MAX_NODES)) u_sym_ram (
    .clk     (clk),
    .wr_en   (sym_we),
    .wr_addr (sym_wa),
    .wr_data (sym_wd),
    .rd_addr (rd_addr),
    .rd_data (sym_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      root_l     <= '0;
      root_r     <= '0;
      nodes_used <= USED_W'(1);
      walk       <= '0;
    end else begin
      if (cmd.clear_tree) begin
        root_l     <= '0;
        root_r     <= '0;
        nodes_used <= USED_W'(1);
        walk       <= '0;
      end
      if (cmd.add_create) begin
        nodes_used <= nodes_used + USED_W'(1);
        if (node_is_root) begin
          if (add_bit) begin
            root_r <= fresh;
          end else begin
            root_l <= fresh;
          end
        end
      end
      if (cmd.dec_invalid || cmd.dec_leaf) begin
        walk <= '0;
      end
      if (cmd.dec_descend) begin
        walk <= dec_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      symbol_r <= in_symbol;
      code_r   <= in_code;
      node     <= '0;
      data_sh  <= in_byte;
      if (32'(in_len) > MAX_CODE_LENGTH) begin
        bits_left <= CNT_W'(MAX_CODE_LENGTH);
      end else begin
        bits_left <= CNT_W'(in_len);
      end
      nbit_cnt <= (in_vbits > BYTE_BITS) ? BYTE_BITS : in_vbits;
    end
    if (cmd.add_follow) begin
      node      <= add_link;
      bits_left <= bits_left - CNT_W'(1);
    end
    if (cmd.add_create) begin
      node <= fresh;
    end
    if (cmd.add_zero) begin
      bits_left <= bits_left - CNT_W'(1);
    end
    if (cmd.dec_load_cur) begin
      cur_l <= (walk == '0) ? root_l : left_q;
      cur_r <= (walk == '0) ? root_r : right_q;
    end
    if (cmd.dec_invalid || cmd.dec_leaf) begin
      cur_l <= root_l;
      cur_r <= root_r;
    end
    if (cmd.dec_descend) begin
      cur_l <= left_q;
      cur_r <= right_q;
    end
    if (cmd.dec_invalid || cmd.dec_leaf || cmd.dec_descend) begin
      data_sh  <= data_sh >> 1;
      nbit_cnt <= nbit_cnt - VBITS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.flush || (cmd.produce && pend_valid)) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
      end else if (cmd.produce) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush) begin
      out_kind <= pend_kind;
      out_sym  <= pend_sym;
      out_last <= 1'b1;
    end else if (cmd.produce) begin
      if (pend_valid) begin
        out_kind <= pend_kind;
        out_sym  <= pend_sym;
        out_last <= 1'b0;
      end
      pend_kind <= cmd.produce_kind;
      pend_sym  <= new_sym;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_sym;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  assign st.in_action     = s_tuser;
  assign st.in_len_zero   = (in_len == '0);
  assign st.in_nbits_zero = (in_vbits == '0);
  assign st.add_link_zero = (add_link == '0);
  assign st.full          = (nodes_used == USED_W'(MAX_NODES));
  assign st.add_last      = add_last;
  assign st.dec_next_zero = (dec_next == '0);
  assign st.dec_leaf      = (left_q == '0) && (right_q == '0);
  assign st.dec_last      = (nbit_cnt == VBITS_W'(1));
  assign st.pend_valid    = pend_valid;
  assign st.slot_free     = slot_free;

endmodule

### src/pctd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prefix code tree decoder controller
// Sequences code loads, tree clears and bitwise decode walks.
// ----------------------------------------------------------------------------
module pctd_ctrl import pctd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_valid,
  output logic    s_ready,
  input  status_t st,
  output cmd_t    cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_ADD_RD    = 4'd1;
  localparam logic [3:0] S_ADD_EV    = 4'd2;
  localparam logic [3:0] S_ADD_ZERO  = 4'd3;
  localparam logic [3:0] S_DEC_FETCH = 4'd4;
  localparam logic [3:0] S_DEC_LOAD  = 4'd5;
  localparam logic [3:0] S_DEC_STEP  = 4'd6;
  localparam logic [3:0] S_DEC_CHECK = 4'd7;
  localparam logic [3:0] S_FINISH    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       can_produce;

  assign can_produce = !st.pend_valid || st.slot_free;
  assign s_ready     = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_NODE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_valid) begin
          cmd.load = 1'b1;
          case (st.in_action)
            ACT_ADD: begin
              if (st.in_len_zero) begin
                cmd.produce      = 1'b1;
                cmd.produce_kind = KIND_DONE;
                state_next       = S_FINISH;
              end else begin
                state_next = S_ADD_RD;
              end
            end
            ACT_DECODE: begin
              if (!st.in_nbits_zero) begin
                state_next = S_DEC_FETCH;
              end
            end
            ACT_CLEAR: begin
              cmd.clear_tree   = 1'b1;
              cmd.produce      = 1'b1;
              cmd.produce_kind = KIND_DONE;
              state_next       = S_FINISH;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_ADD_RD: begin
        state_next = S_ADD_EV;
      end
      S_ADD_EV: begin
        if (!st.add_link_zero) begin
          cmd.add_follow = 1'b1;
          if (st.add_last) begin
            cmd.produce      = 1'b1;
            cmd.produce_kind = KIND_DONE;
            state_next       = S_FINISH;
          end else begin
            state_next = S_ADD_RD;
          end
        end else if (st.full) begin
          cmd.produce      = 1'b1;
          cmd.produce_kind = KIND_FULL;
          state_next       = S_FINISH;
        end else begin
          cmd.add_create = 1'b1;
          state_next     = S_ADD_ZERO;
        end
      end
      S_ADD_ZERO: begin
        cmd.add_zero = 1'b1;
        if (st.add_last) begin
          cmd.produce      = 1'b1;
          cmd.produce_kind = KIND_DONE;
          state_next       = S_FINISH;
        end else begin
          state_next = S_ADD_RD;
        end
      end
      S_DEC_FETCH: begin
        cmd.rd_sel = RD_WALK;
        state_next = S_DEC_LOAD;
      end
      S_DEC_LOAD: begin
        cmd.rd_sel       = RD_WALK;
        cmd.dec_load_cur = 1'b1;
        state_next       = S_DEC_STEP;
      end
      S_DEC_STEP: begin
        cmd.rd_sel = RD_NEXT;
        if (st.dec_next_zero) begin
          if (can_produce) begin
            cmd.produce      = 1'b1;
            cmd.produce_kind = KIND_INVALID;
            cmd.dec_invalid  = 1'b1;
            state_next       = st.dec_last ? S_FINISH : S_DEC_STEP;
          end
        end else begin
          state_next = S_DEC_CHECK;
        end
      end
      S_DEC_CHECK: begin
        cmd.rd_sel = RD_NEXT;
        if (st.dec_leaf) begin
          if (can_produce) begin
            cmd.produce      = 1'b1;
            cmd.produce_kind = KIND_SYMBOL;
            cmd.dec_leaf     = 1'b1;
            state_next       = st.dec_last ? S_FINISH : S_DEC_STEP;
          end
        end else begin
          cmd.dec_descend = 1'b1;
          state_next      = st.dec_last ? S_FINISH : S_DEC_STEP;
        end
      end
      S_FINISH: begin
        if (!st.pend_valid) begin
          state_next = S_IDLE;
        end else if (st.slot_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/prefix_code_tree_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prefix code tree decoder core
// Huffman decoder whose code table is a binary node tree held in RAM.
// ----------------------------------------------------------------------------
// One item is handled at a time, and the node RAMs need no clearing pass
// after reset. Once its transaction is accepted, a decode item fetches the
// current walk node, then for each bit either meets a missing child or steps
// into a node, and then closes the item. An add item follows each existing
// node on the code path and creates each missing one while the table has
// room, then closes the item. Clear resets the tree and closes the item. A
// decode with no valid bits and an unknown action leave the controller idle.
// A stalled output holds back each result and the close of the item. The
// walk is paced by the registered read port of the node RAMs, which puts
// one dependent read on every step of the walk. Results leave through an
// output register, and each one is held back until the next result or the
// end of its item so that tlast can be set on the final one.
// ----------------------------------------------------------------------------
module prefix_code_tree_decoder_core import pctd_pkg::*; #(
  parameter int MAX_NODES       = 512,
  parameter int MAX_CODE_LENGTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // symbol_index, code_bits, code_length, data_byte, valid_bits, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // action
  input  logic [ACTION_W-1:0]   s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // symbol
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // kind
  output logic [KIND_W-1:0]     m_axis_tuser,
  output logic                  m_axis_tlast
);

  cmd_t    cmd;
  status_t st;

  pctd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .st      (st),
    .cmd     (cmd)
  );

  pctd_datapath #(
    .MAX_NODES       (MAX_NODES),
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser),
    .cmd      (cmd),
    .st       (st),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata),
    .m_tuser  (m_axis_tuser),
    .m_tlast  (m_axis_tlast)
  );

  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !st.pend_valid)
    else $error("A result is still held back while a new transaction is accepted.");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.produce && st.pend_valid) |-> st.slot_free)
    else $error("A held result was pushed into a full output register.");

  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != KIND_SYMBOL)) |-> (m_axis_tdata == '0))
    else $error("A result that is not a symbol carries a nonzero symbol.");

  assert property (@(posedge clk) disable iff (rst)
    cmd.add_create |-> !st.full)
    else $error("A node was created in a full node table.");

endmodule
